// ----- sv/key_click_long_press_detector_unit_defines.svh -----
// Assertion macros for the key click / long-press detector checker
`ifndef KEY_CLICK_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH
`define KEY_CLICK_LONG_PRESS_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KCLPD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define KCLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/kclpd_pkg.sv -----
// Shared constants and types for the key click / long-press detector
package kclpd_pkg;

    localparam int NUM_KEYS_DEF   = 4;
    localparam int TIMER_BITS_DEF = 16;
    localparam int RAW_BITS       = 4;
    localparam int OUT_BITS       = 4;
    localparam int DT_BITS        = 8;
    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 1;

    localparam logic [CFG_BITS-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RST = 16'd1000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DEBOUNCE   = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } t_cfg_idx;

    // per-key result of one sample
    typedef struct packed {
        logic click;
        logic long_press;
        logic stable;
    } t_key_evt;

endpackage

// ----- sv/kclpd_key_cell.sv -----
// Per-key debounce, hold timers and click / long-press decision
module kclpd_key_cell
    import kclpd_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_raw,
    input  logic [DT_BITS-1:0]  i_dt,
    input  logic [CFG_BITS-1:0] i_debounce,
    input  logic [CFG_BITS-1:0] i_long_press,
    output t_key_evt            o_evt
);

    localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

    logic                  r_raw_pressed, n_raw_pressed;
    logic [TIMER_BITS-1:0] r_raw_hold, n_raw_hold;
    logic                  r_last_stable, n_last_stable;
    logic [TIMER_BITS-1:0] r_stable_hold, n_stable_hold;
    logic                  r_long_fired, n_long_fired;

    logic [TIMER_BITS:0]   raw_sum;
    logic [TIMER_BITS:0]   stable_sum;
    logic [TIMER_BITS-1:0] raw_sat;
    logic [TIMER_BITS-1:0] stable_sat;
    logic                  stable;

    // saturating timer increments
    assign raw_sum    = {1'b0, r_raw_hold} + (TIMER_BITS+1)'(i_dt);
    assign stable_sum = {1'b0, r_stable_hold} + (TIMER_BITS+1)'(i_dt);
    assign raw_sat    = raw_sum[TIMER_BITS] ? '1 : raw_sum[TIMER_BITS-1:0];
    assign stable_sat = stable_sum[TIMER_BITS] ? '1 : stable_sum[TIMER_BITS-1:0];

    always_comb begin
        n_raw_pressed = i_raw;
        n_raw_hold    = '0;
        if (i_raw && r_raw_pressed) begin
            n_raw_hold = raw_sat;
        end

        stable = n_raw_pressed && (CMP_BITS'(n_raw_hold) >= CMP_BITS'(i_debounce));

        n_last_stable   = stable;
        n_stable_hold   = r_stable_hold;
        n_long_fired    = r_long_fired;
        o_evt.click      = 1'b0;
        o_evt.long_press = 1'b0;
        o_evt.stable     = stable;

        if (stable != r_last_stable) begin
            if (stable) begin
                n_stable_hold = '0;
                n_long_fired  = 1'b0;
            end else begin
                o_evt.click = !r_long_fired;
            end
        end else if (stable) begin
            n_stable_hold = stable_sat;
            if (!r_long_fired &&
                (CMP_BITS'(stable_sat) >= CMP_BITS'(i_long_press))) begin
                o_evt.long_press = 1'b1;
                n_long_fired     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_pressed <= 1'b0;
            r_raw_hold    <= '0;
            r_last_stable <= 1'b0;
            r_stable_hold <= '0;
            r_long_fired  <= 1'b0;
        end else if (i_en) begin
            r_raw_pressed <= n_raw_pressed;
            r_raw_hold    <= n_raw_hold;
            r_last_stable <= n_last_stable;
            r_stable_hold <= n_stable_hold;
            r_long_fired  <= n_long_fired;
        end
    end

endmodule

// ----- sv/kclpd_result_reg.sv -----
// Result register: packs per-key events into the output transaction
module kclpd_result_reg
    import kclpd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [NUM_KEYS-1:0] i_click,
    input  logic [NUM_KEYS-1:0] i_long_press,
    input  logic [NUM_KEYS-1:0] i_stable,
    input  logic                i_stall,
    output logic                o_ready,
    output logic                o_valid,
    output logic [OUT_BITS-1:0] o_click_keys,
    output logic [OUT_BITS-1:0] o_long_press_keys,
    output logic [OUT_BITS-1:0] o_stable_keys,
    output logic                o_any_stable,
    output logic                o_key_event
);

    logic                r_valid;
    logic [OUT_BITS-1:0] r_click, r_long, r_stable;
    logic                r_any, r_event;
    logic [OUT_BITS-1:0] n_click, n_long, n_stable;

    // keys past the output width are dropped, missing keys read as zero
    for (genvar j = 0; j < OUT_BITS; j++) begin : g_fold
        if (j < NUM_KEYS) begin : g_key
            assign n_click[j]  = i_click[j];
            assign n_long[j]   = i_long_press[j];
            assign n_stable[j] = i_stable[j];
        end else begin : g_none
            assign n_click[j]  = 1'b0;
            assign n_long[j]   = 1'b0;
            assign n_stable[j] = 1'b0;
        end
    end

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_click  <= n_click;
            r_long   <= n_long;
            r_stable <= n_stable;
            r_any    <= |i_stable;
            r_event  <= |(i_click | i_long_press);
        end
    end

    assign o_valid           = r_valid;
    assign o_click_keys      = r_click;
    assign o_long_press_keys = r_long;
    assign o_stable_keys     = r_stable;
    assign o_any_stable      = r_any;
    assign o_key_event       = r_event;

endmodule

// ----- sv/key_click_long_press_detector_unit.sv -----
// Top level of the key click / long-press detector
// Each input transaction is one sample of the raw key levels plus the milliseconds since the
// previous sample; it yields exactly one output transaction with the clicks, long presses and
// debounced state of that sample. A sample is captured in an input register, then one shallow
// pass of per-key saturating adds and threshold compares updates the key state and fills the
// result register; a new sample is taken every cycle as long as the output side keeps up. The
// user must write thresholds through the configuration port while idle; it is not enforced.
module key_click_long_press_detector_unit
    import kclpd_pkg::*;
#(
    parameter int NUM_KEYS   = NUM_KEYS_DEF,
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [RAW_BITS-1:0]     i_raw_keys,
    input  logic [DT_BITS-1:0]      i_elapsed_ms,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [OUT_BITS-1:0]     o_click_keys,
    output logic [OUT_BITS-1:0]     o_long_press_keys,
    output logic [OUT_BITS-1:0]     o_stable_keys,
    output logic                    o_any_stable,
    output logic                    o_key_event,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    logic [CFG_BITS-1:0] r_debounce;
    logic [CFG_BITS-1:0] r_long_press;

    logic                r_in_valid;
    logic [RAW_BITS-1:0] r_raw;
    logic [DT_BITS-1:0]  r_dt;

    logic                out_ready;
    logic                advance;
    logic                in_accept;
    logic [NUM_KEYS-1:0] key_raw;
    logic [NUM_KEYS-1:0] key_click;
    logic [NUM_KEYS-1:0] key_long;
    logic [NUM_KEYS-1:0] key_stable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_long_press <= LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                CFG_LONG_PRESS: r_long_press <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign advance   = r_in_valid && out_ready;
    assign o_stall   = !i_rst_n || (r_in_valid && !out_ready);
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_raw <= i_raw_keys;
            r_dt  <= i_elapsed_ms;
        end
    end

    for (genvar i = 0; i < NUM_KEYS; i++) begin : g_keys
        t_key_evt evt;

        if (i < RAW_BITS) begin : g_raw
            assign key_raw[i] = r_raw[i];
        end else begin : g_no_raw
            assign key_raw[i] = 1'b0;
        end

        kclpd_key_cell #(
            .TIMER_BITS(TIMER_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (advance),
            .i_raw        (key_raw[i]),
            .i_dt         (r_dt),
            .i_debounce   (r_debounce),
            .i_long_press (r_long_press),
            .o_evt        (evt)
        );

        assign key_click[i]  = evt.click;
        assign key_long[i]   = evt.long_press;
        assign key_stable[i] = evt.stable;
    end

    kclpd_result_reg #(
        .NUM_KEYS(NUM_KEYS)
    ) u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (advance),
        .i_click           (key_click),
        .i_long_press      (key_long),
        .i_stable          (key_stable),
        .i_stall           (i_stall),
        .o_ready           (out_ready),
        .o_valid           (o_valid),
        .o_click_keys      (o_click_keys),
        .o_long_press_keys (o_long_press_keys),
        .o_stable_keys     (o_stable_keys),
        .o_any_stable      (o_any_stable),
        .o_key_event       (o_key_event)
    );

endmodule

// ----- sv/kclpd_checker.sv -----
// Port-level checker for the key click / long-press detector, bound to the top level
`include "key_click_long_press_detector_unit_defines.svh"

module kclpd_checker
    import kclpd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input logic [OUT_BITS-1:0] o_click_keys,
    input logic [OUT_BITS-1:0] o_long_press_keys,
    input logic [OUT_BITS-1:0] o_stable_keys,
    input logic                o_any_stable,
    input logic                o_key_event
);

    logic                  any_ok;
    logic                  event_ok;
    logic                  click_ok;
    logic                  long_ok;
    logic [3*OUT_BITS-1:0] out_bits;

    assign any_ok   = (o_any_stable == (|o_stable_keys));
    assign event_ok = (o_key_event == (|(o_click_keys | o_long_press_keys)));
    assign click_ok = ((o_click_keys & o_stable_keys) == '0);
    assign long_ok  = ((o_long_press_keys & ~o_stable_keys) == '0);
    assign out_bits = {o_click_keys, o_long_press_keys, o_stable_keys};

    // summary bits agree with the per-key vectors
    `KCLPD_ASSERT_NOW(a_any_stable, i_clk, i_rst_n, o_valid, any_ok, "any_stable mismatch")
    `KCLPD_ASSERT_NOW(a_key_event, i_clk, i_rst_n, o_valid, event_ok, "key_event mismatch")
    // a click completes on release, a long press fires while held
    `KCLPD_ASSERT_NOW(a_click_released, i_clk, i_rst_n, o_valid, click_ok, "click on held key")
    `KCLPD_ASSERT_NOW(a_long_held, i_clk, i_rst_n, o_valid, long_ok, "long press on free key")
    `KCLPD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_bits), "stall change")

endmodule

bind key_click_long_press_detector_unit kclpd_checker u_kclpd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_click_keys      (o_click_keys),
    .o_long_press_keys (o_long_press_keys),
    .o_stable_keys     (o_stable_keys),
    .o_any_stable      (o_any_stable),
    .o_key_event       (o_key_event)
);

// ----- verif/key_click_long_press_detector_unit_test.sv -----
// Self-checking testbench for the key click / long-press detector
`timescale 1ns / 1ps

module key_click_long_press_detector_unit_test;
    import kclpd_pkg::*;

    localparam int NUM_KEYS     = NUM_KEYS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [OUT_BITS-1:0] click;
        logic [OUT_BITS-1:0] long_press;
        logic [OUT_BITS-1:0] stable;
        logic                any_stable;
        logic                key_event;
    } t_key_report;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [RAW_BITS-1:0]     i_raw_keys = '0;
    logic [DT_BITS-1:0]      i_elapsed_ms = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic [OUT_BITS-1:0]     o_click_keys;
    logic [OUT_BITS-1:0]     o_long_press_keys;
    logic [OUT_BITS-1:0]     o_stable_keys;
    logic                    o_any_stable;
    logic                    o_key_event;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    key_click_long_press_detector_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_raw_keys        (i_raw_keys),
        .i_elapsed_ms      (i_elapsed_ms),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_click_keys      (o_click_keys),
        .o_long_press_keys (o_long_press_keys),
        .o_stable_keys     (o_stable_keys),
        .o_any_stable      (o_any_stable),
        .o_key_event       (o_key_event),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the key state and thresholds
    logic [CFG_BITS-1:0] debounce_thresh;
    logic [CFG_BITS-1:0] long_thresh;
    logic                raw_down       [NUM_KEYS];
    logic [15:0]         raw_held_ms    [NUM_KEYS];
    logic                was_stable     [NUM_KEYS];
    logic [15:0]         stable_held_ms [NUM_KEYS];
    logic                long_done      [NUM_KEYS];

    t_key_report pending_reports[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_request = 0;
    int          quiet_cycles = 0;

    function automatic logic [15:0] sat_add(input logic [15:0] t, input logic [DT_BITS-1:0] d);
        logic [16:0] s;
        s = {1'b0, t} + 17'(d);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic t_key_report debounce_step(input logic [RAW_BITS-1:0] raw,
                                                  input logic [DT_BITS-1:0] dt);
        t_key_report rep;
        logic        now_stable;
        int          k;
        rep = '0;
        for (k = 0; k < NUM_KEYS; k++) begin
            if (raw[k]) begin
                raw_held_ms[k] = raw_down[k] ? sat_add(raw_held_ms[k], dt) : 16'd0;
                raw_down[k] = 1'b1;
            end else begin
                raw_down[k] = 1'b0;
                raw_held_ms[k] = 16'd0;
            end
            now_stable = raw_down[k] && (raw_held_ms[k] >= debounce_thresh);
            if (now_stable != was_stable[k]) begin
                if (now_stable) begin
                    stable_held_ms[k] = 16'd0;
                    long_done[k] = 1'b0;
                end else if (!long_done[k]) begin
                    rep.click[k] = 1'b1;
                end
                was_stable[k] = now_stable;
            end else if (now_stable) begin
                stable_held_ms[k] = sat_add(stable_held_ms[k], dt);
                if (!long_done[k] && stable_held_ms[k] >= long_thresh) begin
                    rep.long_press[k] = 1'b1;
                    long_done[k] = 1'b1;
                end
            end
            rep.stable[k] = now_stable;
        end
        rep.any_stable = |rep.stable;
        rep.key_event = |(rep.click | rep.long_press);
        return rep;
    endfunction

    // Monitor: config writes and accepted samples update the shadow state, results are checked
    always @(posedge i_clk) begin
        t_key_report want;
        if (!i_rst_n) begin
            debounce_thresh = DEBOUNCE_RST;
            long_thresh = LONG_PRESS_RST;
            for (int k = 0; k < NUM_KEYS; k++) begin
                raw_down[k] = 1'b0;
                raw_held_ms[k] = '0;
                was_stable[k] = 1'b0;
                stable_held_ms[k] = '0;
                long_done[k] = 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DEBOUNCE:   debounce_thresh = i_cfg_data;
                    CFG_LONG_PRESS: long_thresh = i_cfg_data;
                    default:        ;
                endcase
            end
            if (i_valid && !o_stall)
                pending_reports.push_back(debounce_step(i_raw_keys, i_elapsed_ms));
            if (o_valid && !i_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected transaction: click=%h long=%h stable=%h",
                           o_click_keys, o_long_press_keys, o_stable_keys);
                    fail_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_click_keys !== want.click) begin
                        $error("click_keys: expected %h, got %h", want.click, o_click_keys);
                        fail_count++;
                    end
                    if (o_long_press_keys !== want.long_press) begin
                        $error("long_press_keys: expected %h, got %h",
                               want.long_press, o_long_press_keys);
                        fail_count++;
                    end
                    if (o_stable_keys !== want.stable) begin
                        $error("stable_keys: expected %h, got %h", want.stable, o_stable_keys);
                        fail_count++;
                    end
                    if (o_any_stable !== want.any_stable) begin
                        $error("any_stable: expected %b, got %b", want.any_stable, o_any_stable);
                        fail_count++;
                    end
                    if (o_key_event !== want.key_event) begin
                        $error("key_event: expected %b, got %b", want.key_event, o_key_event);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            i_stall = 1'b1;
            hold_request--;
        end else begin
            i_stall = ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [RAW_BITS-1:0] raw, input logic [DT_BITS-1:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_raw_keys = raw;
        i_elapsed_ms = dt;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Reset thresholds: slow press, fast click, long press then release without click
    task automatic test_default_thresholds();
        send_sample(4'hF, 8'd0);
        send_sample(4'hF, 8'd19);
        send_sample(4'hF, 8'd1);
        send_sample(4'h0, 8'd255);
        send_sample(4'hF, 8'd0);
        send_sample(4'hF, 8'd255);
        repeat (4) send_sample(4'hF, 8'd255);
        send_sample(4'h3, 8'd10);
        send_sample(4'h0, 8'd10);
        wait_drained();
    endtask

    // Zero debounce and zero long-press time
    task automatic test_zero_thresholds();
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_LONG_PRESS, 16'd0);
        send_sample(4'h5, 8'd0);
        send_sample(4'h5, 8'd0);
        send_sample(4'h0, 8'd0);
        send_sample(4'hA, 8'd0);
        send_sample(4'h0, 8'd7);
        send_sample(4'hF, 8'd255);
        send_sample(4'hF, 8'd0);
        send_sample(4'h0, 8'd128);
        wait_drained();
    endtask

    // Both timers run into saturation with maximum thresholds
    task automatic test_timer_saturation();
        write_reg(CFG_DEBOUNCE, 16'hFFFF);
        write_reg(CFG_LONG_PRESS, 16'hFFFF);
        send_sample(4'h9, 8'd0);
        repeat (265) send_sample(4'h9, 8'd255);
        send_sample(4'h1, 8'd255);
        repeat (260) send_sample(4'h1, 8'd255);
        send_sample(4'h0, 8'd255);
        wait_drained();
    endtask

    // Mostly held keys with occasional toggles, plus some raw noise
    task automatic test_random_traffic(input int n_items, input int idle_pct, input int st_pct);
        logic [RAW_BITS-1:0] keys;
        logic [DT_BITS-1:0]  dt;
        logic [CFG_BITS-1:0] val;
        keys = '0;
        send_idle_pct = idle_pct;
        stall_pct = st_pct;
        case ($urandom_range(9))
            0:       val = 16'd0;
            1:       val = 16'hFFFF;
            default: val = 16'($urandom_range(0, 60));
        endcase
        write_reg(CFG_DEBOUNCE, val);
        case ($urandom_range(9))
            0:       val = 16'd0;
            1:       val = 16'hFFFF;
            default: val = 16'($urandom_range(0, 1500));
        endcase
        write_reg(CFG_LONG_PRESS, val);
        repeat (n_items) begin
            if ($urandom_range(99) < 12) begin
                keys = 4'($urandom);
                dt = 8'($urandom);
            end else begin
                for (int k = 0; k < NUM_KEYS; k++)
                    if ($urandom_range(15) == 0) keys[k] = ~keys[k];
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: dt = 8'($urandom_range(0, 40));
                    6, 7, 8:          dt = 8'($urandom_range(40, 255));
                    default:          dt = ($urandom_range(1)) ? 8'd255 : 8'd0;
                endcase
            end
            send_sample(keys, dt);
        end
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering, so the block fills and stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        write_reg(CFG_DEBOUNCE, 16'd5);
        write_reg(CFG_LONG_PRESS, 16'd40);
        @(posedge i_clk);
        hold_request = 300;
        for (int n = 0; n < 40; n++)
            send_sample((n % 8 < 5) ? 4'hC : 4'h3, 8'($urandom_range(0, 20)));
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_thresholds();
        test_zero_thresholds();
        test_timer_saturation();
        test_random_traffic(340, 0, 0);
        test_random_traffic(340, 59, 0);
        test_random_traffic(340, 0, 59);
        test_random_traffic(340, 19, 19);
        test_backpressure();

        wait_drained();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
